/* rtl/bmsc_pkg.sv */
// Package for the bit matrix block: sizes, request codes, state encoding.
// No dependencies.
package bmsc_pkg;
    localparam int MAX_BITS   = 4096;
    localparam int WORD_COUNT = (MAX_BITS + 63) / 64;
    localparam int WA_W       = $clog2(WORD_COUNT);
    localparam int CFG_W      = 13;
    localparam int IDX_W      = $clog2(MAX_BITS) + 13;

    typedef enum logic [2:0] {
        REQ_SET = 3'd0, REQ_CLEAR = 3'd1, REQ_TEST = 3'd2, REQ_COUNT = 3'd3,
        REQ_FIRST = 3'd4, REQ_EMPTY = 3'd5, REQ_SINGLE = 3'd6, REQ_CLEAR_ALL = 3'd7
    } req_t;

    typedef enum logic [0:0] { CFG_NUM_ROWS = 1'b0, CFG_NUM_COLUMNS = 1'b1 } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_BIT, ST_WALK, ST_WIPE, ST_DONE
    } state_t;
endpackage

/* rtl/bmsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bmsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/bit_matrix_set_count_find.sv */
// Top level of the bit matrix block: control sequencer around one word RAM.
// Depends on bmsc_pkg and bmsc_ram.
//
// A num_rows by num_columns bit matrix packed row-major in 64-bit words of one
// RAM. Each request word returns one result word. Set, clear and test step
// through accept, check, read, modify and write back, and result. Count, empty,
// single and first-set walk the row one bit per cycle through the RAM read
// port; each new 64-bit word first needs a fresh read. The walk covers the
// num_columns bits of the row (from column on for first-set, where a set bit
// ends the search early). Clear all, and reset, sweep the RAM one word per
// cycle; no request is accepted during the sweep (configuration writes are
// still taken). The next request is taken once the result word has been
// accepted.
module bit_matrix_set_count_find
    import bmsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [11:0]       s_row,
    input  logic [11:0]       s_column,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_bit_value,
    output logic              m_changed,
    output logic [12:0]       m_row_count,
    output logic signed [12:0] m_first_position,
    output logic              m_row_empty,
    output logic              m_row_single,
    output logic              m_range_error
);
    state_t state_reg, state_next;
    logic [CFG_W-1:0] rows_reg, cols_reg;
    req_t             req_reg;
    logic [11:0]      row_reg, col_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [12:0]      pos_reg, pos_next;   // current column of the walk
    logic [12:0]      cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic             rd_pend_reg, rd_pend_next; // rdata holds word of idx_reg
    logic [WA_W:0]    wipe_reg, wipe_next;
    logic             err_next, err_reg;

    logic             ram_we;
    logic [WA_W-1:0]  ram_waddr, ram_raddr;
    logic [63:0]      ram_wdata, ram_rdata;

    bmsc_ram #(.WIDTH(64), .DEPTH(WORD_COUNT)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // Range check on the captured request.
    logic [IDX_W-1:0] base_calc;
    logic             fail;
    assign base_calc = IDX_W'(row_reg) * IDX_W'(cols_reg);
    always_comb begin
        logic needs_col;
        needs_col = (req_reg == REQ_SET) || (req_reg == REQ_CLEAR)
                 || (req_reg == REQ_TEST) || (req_reg == REQ_FIRST);
        fail = (13'(row_reg) >= rows_reg) || (needs_col && 13'(col_reg) >= cols_reg)
            || ((base_calc + IDX_W'(cols_reg)) > IDX_W'(MAX_BITS));
    end

    logic rbit;
    assign rbit = ram_rdata[idx_reg[5:0]];
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        rd_pend_next = 1'b0;
        wipe_next    = wipe_reg;
        err_next     = err_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[WA_W+5:6];
        ram_wdata    = ram_rdata;
        ram_raddr    = idx_reg[WA_W+5:6];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next   = '0;
                found_next = 1'b0;
                err_next   = 1'b0;
                if (req_reg == REQ_CLEAR_ALL) begin
                    wipe_next  = '0;
                    state_next = ST_WIPE;
                end else if (fail) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (req_reg == REQ_SET || req_reg == REQ_CLEAR
                          || req_reg == REQ_TEST) begin
                    idx_next   = base_calc + IDX_W'(col_reg);
                    state_next = ST_BIT;
                end else begin
                    pos_next   = (req_reg == REQ_FIRST) ? 13'(col_reg) : '0;
                    idx_next   = base_calc + ((req_reg == REQ_FIRST) ? IDX_W'(col_reg) : '0);
                    state_next = ST_WALK;
                end
            end
            ST_BIT: begin
                // Issue the read, then modify and write back on the next cycle.
                if (!rd_pend_reg) begin
                    rd_pend_next = 1'b1;
                end else begin
                    found_next = rbit;
                    if (req_reg != REQ_TEST) begin
                        ram_we = 1'b1;
                        ram_wdata[idx_reg[5:0]] = (req_reg == REQ_SET);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (pos_reg >= cols_reg || found_reg) begin
                    state_next = ST_DONE;
                end else if (!rd_pend_reg) begin
                    rd_pend_next = 1'b1;
                end else begin
                    if (rbit) begin
                        cnt_next = cnt_reg + 13'd1;
                        if (req_reg == REQ_FIRST) begin
                            found_next = 1'b1;
                        end
                    end
                    if (!(rbit && req_reg == REQ_FIRST)) begin
                        pos_next = pos_reg + 13'd1;
                        idx_next = idx_reg + IDX_W'(1);
                        // Same word still in rdata unless crossing a boundary.
                        rd_pend_next = (idx_reg[5:0] != 6'h3f);
                    end
                end
            end
            ST_WIPE: begin
                ram_we    = 1'b1;
                ram_waddr = wipe_reg[WA_W-1:0];
                ram_wdata = '0;
                wipe_next = wipe_reg + 1'b1;
                if (wipe_reg == (WA_W+1)'(WORD_COUNT - 1)) begin
                    state_next = (req_reg == REQ_CLEAR_ALL && found_reg)
                               ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WIPE;
            wipe_reg    <= '0;
            rows_reg    <= 13'd1;
            cols_reg    <= 13'd4096;
            rd_pend_reg <= 1'b0;
            req_reg     <= REQ_CLEAR_ALL;
            found_reg   <= 1'b1;   // reset sweep: no result word afterwards
            err_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wipe_reg    <= wipe_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
            err_reg     <= err_next;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_NUM_ROWS:    rows_reg <= cfg_data;
                    CFG_NUM_COLUMNS: cols_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                req_reg <= req_t'(s_req_type);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            row_reg <= s_row;
            col_reg <= s_column;
        end
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        cnt_reg  <= cnt_next;
    end

    logic ok;
    assign ok = !err_reg && (state_reg == ST_DONE);
    assign m_valid          = (state_reg == ST_DONE);
    assign m_range_error    = err_reg;
    assign m_bit_value      = ok && req_reg == REQ_TEST && found_reg;
    assign m_changed        = ok && ((req_reg == REQ_SET && !found_reg)
                                  || (req_reg == REQ_CLEAR && found_reg));
    assign m_row_count      = (ok && req_reg == REQ_COUNT) ? cnt_reg : '0;
    assign m_first_position = (ok && req_reg == REQ_FIRST && found_reg)
                              ? $signed(pos_reg) : -13'sd1;
    assign m_row_empty      = ok && req_reg == REQ_EMPTY && cnt_reg == '0;
    assign m_row_single     = ok && req_reg == REQ_SINGLE && cnt_reg == 13'd1;

    // A request is only taken in idle, and a result only shown when done.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready |-> !m_valid)) else $error("ready while result pending");
    // A held result keeps its error flag until taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready |=> m_valid && $stable(m_range_error)))
        else $error("result dropped");
    // RAM never written while a result waits.
    a_no_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid |-> !ram_we)) else $error("write in done state");
endmodule
